>>> hw/rtl/stereo_correlation_meter_defines.svh
// ----------------------------------------------------------------------------
// stereo correlation meter assertion macros
// clocked property checks used by the meter's top-level rtl file
// ----------------------------------------------------------------------------
`ifndef STEREO_CORRELATION_METER_DEFINES_SVH
`define STEREO_CORRELATION_METER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SCM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// types and fixed widths of the stereo correlation meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scm_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned PRODUCT_W   = 2 * SAMPLE_W;
  localparam int unsigned CROSS_W     = 44;
  localparam int unsigned ENERGY_W    = 43;
  localparam int unsigned WIDE_W      = 2 * ENERGY_W;
  localparam int unsigned ROOT_W      = 43;
  localparam int unsigned REM_W       = ROOT_W + 2;
  localparam int unsigned NUM_W       = CROSS_W + 1;
  localparam int unsigned SCORE_W     = 16;
  localparam int unsigned SCORE_SHIFT = 14;
  localparam int unsigned QUO_W       = 17;
  localparam int unsigned PRE_SHIFT   = QUO_W - SCORE_SHIFT;
  localparam int unsigned STEP_W      = 6;
  localparam int unsigned UNIT_W      = 88;

  localparam logic [SCORE_W-1:0] SCORE_ONE = 16'h8000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       frame_end;
  } scm_in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               overflow;
  } scm_out_t;

  // request to the shared add/subtract unit
  typedef struct packed {
    logic [UNIT_W-1:0] a;
    logic [UNIT_W-1:0] b;
    logic              sub;
  } scm_unit_req_t;

  // carry is the no-borrow flag when subtracting
  typedef struct packed {
    logic [UNIT_W-1:0] sum;
    logic              carry;
  } scm_unit_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_X,
    ST_ADD_L,
    ST_ADD_R,
    ST_PMUL,
    ST_ROOT,
    ST_NUM,
    ST_PRE,
    ST_DIV,
    ST_OUT
  } scm_state_e;

endpackage

>>> hw/rtl/scm_addsub.sv
// ----------------------------------------------------------------------------
// scm_addsub
// shared wide add/subtract unit with carry out, reused by every step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scm_addsub (
  input  scm_pkg::scm_unit_req_t req_i,
  output scm_pkg::scm_unit_rsp_t rsp_o
);

  localparam int unsigned UnitW = scm_pkg::UNIT_W;

  logic [UnitW-1:0] b_eff;
  logic [UnitW:0]   total;

  assign b_eff = req_i.b ^ {UnitW{req_i.sub}};
  assign total = {1'b0, req_i.a} + {1'b0, b_eff} + (UnitW + 1)'(req_i.sub);

  assign rsp_o.sum   = total[UnitW-1:0];
  assign rsp_o.carry = total[UnitW];

endmodule

>>> hw/rtl/stereo_correlation_meter.sv
// ----------------------------------------------------------------------------
// stereo_correlation_meter
// frame-based stereo phase correlation score, Q1.15, one shared adder
// ----------------------------------------------------------------------------
//
//   channel   signals                              direction  payload
//   in        in_valid_i / in_stall_o / in_data_i  to block   scm_in_t
//   out       out_valid_o / out_stall_i / out_data_o from block scm_out_t
//
// - a sample pair steps through accept, cross add, left add and right add in turn;
//   the single adder shared by all steps serialises them; in_stall_o holds the next pair
// - a pair marked frame_end adds 43 multiply steps, 43 root steps, the numerator
//   and range-check setup and up to 17 divide steps before the result beat
// - the result beat holds under out_stall_i; no new pair is taken until it goes
// - reset (and every delivered result) clears the sums, count and overflow flag
`timescale 1ns / 1ps
`include "stereo_correlation_meter_defines.svh"

module stereo_correlation_meter #(
  parameter int unsigned FRAME_MAX = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  scm_pkg::scm_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output scm_pkg::scm_out_t out_data_o
);

  localparam int unsigned CntW     = $clog2(FRAME_MAX + 1);
  localparam int unsigned UnitW    = scm_pkg::UNIT_W;
  localparam int unsigned SampleW  = scm_pkg::SAMPLE_W;
  localparam int unsigned ProductW = scm_pkg::PRODUCT_W;
  localparam int unsigned CrossW   = scm_pkg::CROSS_W;
  localparam int unsigned EnergyW  = scm_pkg::ENERGY_W;
  localparam int unsigned WideW    = scm_pkg::WIDE_W;
  localparam int unsigned RootW    = scm_pkg::ROOT_W;
  localparam int unsigned RemW     = scm_pkg::REM_W;
  localparam int unsigned NumW     = scm_pkg::NUM_W;
  localparam int unsigned ScoreW   = scm_pkg::SCORE_W;
  localparam int unsigned QuoW     = scm_pkg::QUO_W;
  localparam int unsigned StepW    = scm_pkg::STEP_W;
  localparam int unsigned PreShift = scm_pkg::PRE_SHIFT;
  localparam int unsigned ScShift  = scm_pkg::SCORE_SHIFT;

  localparam logic signed [CrossW-1:0] CrossMax = {1'b0, {(CrossW - 1){1'b1}}};
  localparam logic signed [CrossW-1:0] CrossMin = {1'b1, {(CrossW - 1){1'b0}}};
  localparam logic [EnergyW-1:0]       EnergyMax = {EnergyW{1'b1}};
  localparam logic [QuoW-1:0]          QuoOne = {1'b0, scm_pkg::SCORE_ONE};

  scm_pkg::scm_state_e state_q, state_d;

  logic signed [SampleW-1:0]  left_smp_q, left_smp_d;
  logic signed [SampleW-1:0]  right_smp_q, right_smp_d;
  logic                       last_q, last_d;
  logic signed [ProductW-1:0] prod_q, prod_d;
  logic signed [CrossW-1:0]   cross_q, cross_d;
  logic [EnergyW-1:0]         left_q, left_d;
  logic [EnergyW-1:0]         right_q, right_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       sat_q, sat_d;
  logic [WideW-1:0]           wide_q, wide_d;
  logic [RemW-1:0]            rem_q, rem_d;
  logic [RootW-1:0]           root_q, root_d;
  logic signed [NumW-1:0]     num_q, num_d;
  logic [QuoW-1:0]            nlow_q, nlow_d;
  logic [QuoW-2:0]            quo_q, quo_d;
  logic [StepW-1:0]           step_q, step_d;
  logic [ScoreW-1:0]          score_q, score_d;

  logic signed [SampleW-1:0] mul_a;
  logic signed [SampleW-1:0] mul_b;
  logic                      in_beat;
  logic                      cnt_full;
  logic                      num_pos;
  logic                      root_zero;
  logic                      step_last;
  logic [QuoW-1:0]           quo_fin;

  scm_pkg::scm_unit_req_t unit_req;
  scm_pkg::scm_unit_rsp_t unit_rsp;

  scm_addsub u_addsub (
    .req_i (unit_req),
    .rsp_o (unit_rsp)
  );

  assign in_beat   = in_valid_i && (state_q == scm_pkg::ST_IDLE);
  assign cnt_full  = (cnt_q == CntW'(FRAME_MAX));
  assign num_pos   = !num_q[NumW-1] && (num_q != '0);
  assign root_zero = (root_q == '0);
  assign step_last = (step_q == '0);
  assign quo_fin   = {quo_q, unit_rsp.carry};

  // one 16x16 multiplier, three products per pair
  always_comb begin
    case (state_q)
      scm_pkg::ST_ADD_X: begin
        mul_a = left_smp_q;
        mul_b = left_smp_q;
      end
      scm_pkg::ST_ADD_L: begin
        mul_a = right_smp_q;
        mul_b = right_smp_q;
      end
      default: begin
        mul_a = in_data_i.left_sample;
        mul_b = in_data_i.right_sample;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      scm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (!cnt_full) begin
            state_d = scm_pkg::ST_ADD_X;
          end else if (in_data_i.frame_end) begin
            state_d = scm_pkg::ST_PMUL;
          end
        end
      end
      scm_pkg::ST_ADD_X: state_d = scm_pkg::ST_ADD_L;
      scm_pkg::ST_ADD_L: state_d = scm_pkg::ST_ADD_R;
      scm_pkg::ST_ADD_R: begin
        state_d = last_q ? scm_pkg::ST_PMUL : scm_pkg::ST_IDLE;
      end
      scm_pkg::ST_PMUL: begin
        if (step_last) state_d = scm_pkg::ST_ROOT;
      end
      scm_pkg::ST_ROOT: begin
        if (step_last) state_d = scm_pkg::ST_NUM;
      end
      scm_pkg::ST_NUM: begin
        state_d = root_zero ? scm_pkg::ST_OUT : scm_pkg::ST_PRE;
      end
      scm_pkg::ST_PRE: begin
        if (!num_pos || unit_rsp.carry) begin
          state_d = scm_pkg::ST_OUT;
        end else begin
          state_d = scm_pkg::ST_DIV;
        end
      end
      scm_pkg::ST_DIV: begin
        if (step_last) state_d = scm_pkg::ST_OUT;
      end
      scm_pkg::ST_OUT: begin
        if (!out_stall_i) state_d = scm_pkg::ST_IDLE;
      end
      default: state_d = scm_pkg::ST_IDLE;
    endcase
  end

  // datapath and unit operands
  always_comb begin
    unit_req    = '0;
    left_smp_d  = left_smp_q;
    right_smp_d = right_smp_q;
    last_d      = last_q;
    cross_d     = cross_q;
    left_d      = left_q;
    right_d     = right_q;
    cnt_d       = cnt_q;
    sat_d       = sat_q;
    wide_d      = wide_q;
    rem_d       = rem_q;
    root_d      = root_q;
    num_d       = num_q;
    nlow_d      = nlow_q;
    quo_d       = quo_q;
    step_d      = step_q;
    score_d     = score_q;
    case (state_q)
      scm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          left_smp_d  = in_data_i.left_sample;
          right_smp_d = in_data_i.right_sample;
          last_d      = in_data_i.frame_end;
          wide_d      = '0;
          step_d      = StepW'(RootW - 1);
          if (cnt_full) sat_d = 1'b1;
        end
      end
      scm_pkg::ST_ADD_X: begin
        unit_req.a = UnitW'(cross_q);
        unit_req.b = UnitW'(prod_q);
        if (unit_rsp.sum[CrossW] != unit_rsp.sum[CrossW-1]) begin
          cross_d = unit_rsp.sum[CrossW] ? CrossMin : CrossMax;
          sat_d   = 1'b1;
        end else begin
          cross_d = signed'(unit_rsp.sum[CrossW-1:0]);
        end
      end
      scm_pkg::ST_ADD_L: begin
        unit_req.a = UnitW'(left_q);
        unit_req.b = UnitW'(prod_q[ProductW-2:0]);
        if (unit_rsp.sum[EnergyW]) begin
          left_d = EnergyMax;
          sat_d  = 1'b1;
        end else begin
          left_d = unit_rsp.sum[EnergyW-1:0];
        end
      end
      scm_pkg::ST_ADD_R: begin
        unit_req.a = UnitW'(right_q);
        unit_req.b = UnitW'(prod_q[ProductW-2:0]);
        cnt_d      = cnt_q + CntW'(1);
        if (unit_rsp.sum[EnergyW]) begin
          right_d = EnergyMax;
          sat_d   = 1'b1;
        end else begin
          right_d = unit_rsp.sum[EnergyW-1:0];
        end
      end
      scm_pkg::ST_PMUL: begin
        // shift-and-add, msb of the right energy first
        unit_req.a = UnitW'({wide_q[WideW-2:0], 1'b0});
        unit_req.b = right_q[step_q] ? UnitW'(left_q) : '0;
        wide_d     = unit_rsp.sum[WideW-1:0];
        step_d     = step_q - StepW'(1);
        if (step_last) begin
          step_d = StepW'(RootW - 1);
          rem_d  = '0;
          root_d = '0;
        end
      end
      scm_pkg::ST_ROOT: begin
        // restoring square root, two radicand bits a step
        unit_req.a   = UnitW'({rem_q, wide_q[WideW-1 -: 2]});
        unit_req.b   = UnitW'({root_q, 2'b01});
        unit_req.sub = 1'b1;
        wide_d       = {wide_q[WideW-3:0], 2'b00};
        step_d       = step_q - StepW'(1);
        if (unit_rsp.carry) begin
          rem_d  = unit_rsp.sum[RemW-1:0];
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = {rem_q[RemW-3:0], wide_q[WideW-1 -: 2]};
          root_d = {root_q[RootW-2:0], 1'b0};
        end
      end
      scm_pkg::ST_NUM: begin
        unit_req.a = UnitW'(cross_q);
        unit_req.b = UnitW'(root_q);
        num_d      = signed'(unit_rsp.sum[NumW-1:0]);
        if (root_zero) score_d = scm_pkg::SCORE_ONE;
      end
      scm_pkg::ST_PRE: begin
        // quotient of 2^17 or more clamps straight away
        unit_req.a   = UnitW'(num_q[NumW-2:0]);
        unit_req.b   = UnitW'({root_q, {PreShift{1'b0}}});
        unit_req.sub = 1'b1;
        if (!num_pos) begin
          score_d = '0;
        end else if (unit_rsp.carry) begin
          score_d = scm_pkg::SCORE_ONE;
        end else begin
          rem_d  = RemW'(num_q[NumW-2:PreShift]);
          nlow_d = {num_q[PreShift-1:0], {ScShift{1'b0}}};
          step_d = StepW'(QuoW - 1);
        end
      end
      scm_pkg::ST_DIV: begin
        unit_req.a   = UnitW'({rem_q[RootW-1:0], nlow_q[QuoW-1]});
        unit_req.b   = UnitW'(root_q);
        unit_req.sub = 1'b1;
        nlow_d       = {nlow_q[QuoW-2:0], 1'b0};
        quo_d        = quo_fin[QuoW-2:0];
        step_d       = step_q - StepW'(1);
        if (unit_rsp.carry) begin
          rem_d = RemW'(unit_rsp.sum[RootW-1:0]);
        end else begin
          rem_d = RemW'({rem_q[RootW-2:0], nlow_q[QuoW-1]});
        end
        if (step_last) begin
          score_d = (quo_fin > QuoOne) ? scm_pkg::SCORE_ONE : quo_fin[ScoreW-1:0];
        end
      end
      scm_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          cross_d = '0;
          left_d  = '0;
          right_d = '0;
          cnt_d   = '0;
          sat_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scm_pkg::ST_IDLE;
      cross_q <= '0;
      left_q  <= '0;
      right_q <= '0;
      cnt_q   <= '0;
      sat_q   <= 1'b0;
      last_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cross_q <= cross_d;
      left_q  <= left_d;
      right_q <= right_d;
      cnt_q   <= cnt_d;
      sat_q   <= sat_d;
      last_q  <= last_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_smp_q  <= left_smp_d;
    right_smp_q <= right_smp_d;
    prod_q      <= prod_d;
    wide_q      <= wide_d;
    rem_q       <= rem_d;
    root_q      <= root_d;
    num_q       <= num_d;
    nlow_q      <= nlow_d;
    quo_q       <= quo_d;
    score_q     <= score_d;
  end

  assign in_stall_o          = (state_q != scm_pkg::ST_IDLE);
  assign out_valid_o         = (state_q == scm_pkg::ST_OUT);
  assign out_data_o.score    = score_q;
  assign out_data_o.overflow = sat_q;

  `SCM_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(FRAME_MAX),
    "pair count above frame limit")
  `SCM_ASSERT_IMPL(a_score_range, clk_i, rst_ni, out_valid_o,
    out_data_o.score <= scm_pkg::SCORE_ONE, "score above one")
  `SCM_ASSERT_NEXT(a_clear_after_beat, clk_i, rst_ni, out_valid_o && !out_stall_i,
    (cross_q == '0) && (left_q == '0) && (right_q == '0) && (cnt_q == '0) && !sat_q,
    "frame state not cleared after result beat")
  // a dropped pair that does not end the frame leaves the block idle
  `SCM_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni,
    in_beat && (!cnt_full || in_data_i.frame_end), in_stall_o,
    "input not stalled after accepted beat")
  `SCM_ASSERT_IMPL(a_div_root_nonzero, clk_i, rst_ni, state_q == scm_pkg::ST_DIV,
    !root_zero, "divide running with zero root")

endmodule
